// File: src/rmsnorm_backward_gradient_assert.svh
// Assertion macros for the RMS-norm backward gradient block.
`ifndef RMSNORM_BACKWARD_GRADIENT_ASSERT_SVH
`define RMSNORM_BACKWARD_GRADIENT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define RBG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbg: same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define RBG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbg: next-cycle check failed");

`endif

// File: src/rbg_pkg.sv
// Shared types, constants and saturation helpers for the RMS-norm backward block.
package rbg_pkg;

	localparam int MAX_DIM = 4096;
	localparam int CNT_W   = $clog2(MAX_DIM + 1);
	localparam logic [63:0] EPS_Q20 = 64'd10;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] RECIP_NUM = 64'h1000_0000_0000_0000; // 2^60
	localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000; // 2^62

	localparam logic MODE_ACC   = 1'b0;
	localparam logic MODE_APPLY = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] x_value;
		logic signed [31:0] weight;
		logic signed [31:0] grad_out;
		logic signed [31:0] grad_x_in;
		logic signed [31:0] grad_w_in;
		logic               last;
	} rbg_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} rbg_fq_stat_t;

	typedef struct packed {
		logic idle;
		logic pop;
		logic load;
	} rbg_back_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_GW, ST_XX, ST_PX, ST_ACC, ST_MEAN, ST_RECIP, ST_SQRT,
		ST_INV2, ST_INV3, ST_C3, ST_COEF, ST_INVG, ST_CX, ST_GX, ST_WINV, ST_OUT
	} rbg_state_t;

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [63:0] v);
		if ((&v[63:31]) || (~|v[63:31]))
			return v[31:0];
		return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

endpackage

// File: src/rbg_front.sv
// Input side: two-entry item queue between the port and the sequencer.
module rbg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rbg_pkg::rbg_item_t  in_item,
	input  logic                pop,
	output rbg_pkg::rbg_item_t  head,
	output rbg_pkg::rbg_fq_stat_t stat
);
	import rbg_pkg::*;

	rbg_item_t  ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign push      = in_valid && in_ready;
	assign in_ready  = (cnt_q != 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign stat.full  = (cnt_q == 2'd2);
	assign head      = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: src/rbg_mul.sv
// Q20 multiply: 64x64 signed product from four 32x32 partial products, >>20, saturated.
module rbg_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res
);
	import rbg_pkg::*;

	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [2:0]   step_q;
	logic         busy_q, done_q;
	logic [63:0]  res_q;
	logic [31:0]  op_a, op_b;
	logic [63:0]  prod;
	logic [127:0] prod_sh;
	logic [63:0]  mag;
	logic [63:0]  fin;

	always_comb begin
		op_a    = step_q[1] ? ma_q[63:32] : ma_q[31:0];
		op_b    = step_q[0] ? mb_q[63:32] : mb_q[31:0];
		prod    = {32'd0, op_a} * {32'd0, op_b};
		case (step_q)
			3'd0:    prod_sh = {64'd0, prod};
			3'd1,
			3'd2:    prod_sh = {32'd0, prod, 32'd0};
			3'd3:    prod_sh = {prod, 64'd0};
			default: prod_sh = 128'd0;
		endcase
		mag = acc_q[83:20];
		if (acc_q[127:84] != 44'd0)
			fin = neg_q ? S64_MIN : S64_MAX;
		else if (neg_q)
			fin = mag[63] ? S64_MIN : (64'd0 - mag);
		else
			fin = mag[63] ? S64_MAX : mag;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[63] ? (64'd0 - a) : a;
			mb_q  <= b[63] ? (64'd0 - b) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= 128'd0;
		end else if (busy_q && step_q != 3'd4) begin
			acc_q <= acc_q + prod_sh;
		end
		if (busy_q && step_q == 3'd4)
			res_q <= fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: src/rbg_div.sv
// Unsigned 64/64 restoring divider, one quotient bit per cycle.
module rbg_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quot
);
	logic [63:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [65:0] trial;

	assign trial = {1'b0, rem_q, quo_q[63]} - {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[65]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: src/rbg_back.sv
// Sequencer: accumulates pass one, forms inv rms and coefficient, applies pass two.
module rbg_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rbg_pkg::rbg_item_t     head,
	input  rbg_pkg::rbg_fq_stat_t  fstat,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic signed [31:0]     grad_x_out,
	output logic signed [31:0]     grad_w_out,
	output logic                   last_out,
	output rbg_pkg::rbg_back_stat_t stat
);
	import rbg_pkg::*;

	rbg_state_t state_q, state_d;
	rbg_item_t  cur_q;

	logic [63:0]      sum_q, dot_q, coeff_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      inv_rms_q;
	logic [63:0]      gw_q, sq_q, px_q, mean_q, a_q, t_q, u_q, v_q;
	logic [63:0]      srem_q, sr_q, sbit_q;
	logic             issued_q;
	logic             ovalid_q;
	logic [31:0]      gx_out_q, gw_out_q;
	logic             last_out_q;

	logic             mul_start, mul_done, div_start, div_done;
	logic [63:0]      mul_a, mul_b, mul_res, div_n, div_d, div_q;
	logic [63:0]      x64, w64, go64, inv64, n64, ms;
	logic [63:0]      sr_try;
	logic [31:0]      gw_sat;
	logic             pop, load;

	assign x64   = {{32{cur_q.x_value[31]}}, cur_q.x_value};
	assign w64   = {{32{cur_q.weight[31]}}, cur_q.weight};
	assign go64  = {{32{cur_q.grad_out[31]}}, cur_q.grad_out};
	assign inv64 = {32'd0, inv_rms_q};
	assign n64   = {{(64-CNT_W){1'b0}}, cnt_q};
	assign ms    = (mean_q > (S64_MAX - EPS_Q20)) ? S64_MAX : (mean_q + EPS_Q20);
	assign sr_try = sr_q + sbit_q;
	// grad_out*weight clipped to 32 bits before the x product
	assign gw_sat = sat32(gw_q);

	rbg_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .res(mul_res)
	);

	rbg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_n), .divisor(div_d), .done(div_done), .quot(div_q)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (!fstat.empty) state_d = ST_GW;
			ST_GW:    if (mul_done) state_d = (cur_q.mode == MODE_APPLY) ? ST_INVG : ST_XX;
			ST_XX:    if (mul_done) state_d = ST_PX;
			ST_PX:    if (mul_done) state_d = ST_ACC;
			ST_ACC:   state_d = cur_q.last ? ST_MEAN : ST_IDLE;
			ST_MEAN:  if (div_done) state_d = ST_RECIP;
			ST_RECIP: if (div_done) state_d = ST_SQRT;
			ST_SQRT:  if (sbit_q == 64'd0) state_d = ST_INV2;
			ST_INV2:  if (mul_done) state_d = ST_INV3;
			ST_INV3:  if (mul_done) state_d = ST_C3;
			ST_C3:    if (div_done) state_d = ST_COEF;
			ST_COEF:  if (mul_done) state_d = ST_IDLE;
			ST_INVG:  if (mul_done) state_d = ST_CX;
			ST_CX:    if (mul_done) state_d = ST_GX;
			ST_GX:    if (mul_done) state_d = ST_WINV;
			ST_WINV:  if (mul_done) state_d = ST_OUT;
			ST_OUT:   if (!ovalid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// unit operands and strobes
	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = 64'd0;
		mul_b     = 64'd0;
		div_n     = 64'd0;
		div_d     = 64'd1;
		pop       = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE:  pop = !fstat.empty;
			ST_GW:    begin mul_a = go64; mul_b = w64; end
			ST_XX:    begin mul_a = x64; mul_b = x64; end
			ST_PX:    begin
				mul_a = {{32{gw_sat[31]}}, gw_sat};
				mul_b = x64;
			end
			ST_MEAN:  begin div_n = sum_q; div_d = n64; end
			ST_RECIP: begin div_n = RECIP_NUM; div_d = ms; end
			ST_INV2:  begin mul_a = inv64; mul_b = inv64; end
			ST_INV3:  begin mul_a = a_q; mul_b = inv64; end
			ST_C3:    begin div_n = a_q; div_d = n64; end
			ST_COEF:  begin mul_a = a_q; mul_b = dot_q; end
			ST_INVG:  begin mul_a = inv64; mul_b = gw_q; end
			ST_CX:    begin mul_a = coeff_q; mul_b = x64; end
			ST_GX:    begin mul_a = go64; mul_b = x64; end
			ST_WINV:  begin mul_a = v_q; mul_b = inv64; end
			ST_OUT:   load = !ovalid_q || out_ready;
			default:  ;
		endcase
		case (state_q)
			ST_GW, ST_XX, ST_PX, ST_INV2, ST_INV3, ST_COEF,
			ST_INVG, ST_CX, ST_GX, ST_WINV: mul_start = !issued_q;
			ST_MEAN, ST_RECIP, ST_C3:       div_start = !issued_q;
			default: ;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (mul_done) begin
			case (state_q)
				ST_GW:   gw_q <= mul_res;
				ST_XX:   sq_q <= mul_res;
				ST_PX:   px_q <= mul_res;
				ST_INV2,
				ST_INV3: a_q  <= mul_res;
				ST_INVG: t_q  <= mul_res;
				ST_CX:   u_q  <= mul_res;
				ST_GX,
				ST_WINV: v_q  <= mul_res;
				default: ;
			endcase
		end
		if (div_done) begin
			case (state_q)
				ST_MEAN:  mean_q <= div_q;
				ST_C3:    a_q    <= div_q;
				ST_RECIP: begin
					srem_q <= div_q;
					sr_q   <= 64'd0;
					sbit_q <= SQRT_BIT0;
				end
				default: ;
			endcase
		end
		if (state_q == ST_SQRT && sbit_q != 64'd0) begin
			if (srem_q >= sr_try) begin
				srem_q <= srem_q - sr_try;
				sr_q   <= (sr_q >> 1) + sbit_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
		if (load) begin
			gx_out_q   <= sat32(sat_sub64(sat_add64({{32{cur_q.grad_x_in[31]}},
				cur_q.grad_x_in}, t_q), u_q));
			gw_out_q   <= sat32(sat_add64({{32{cur_q.grad_w_in[31]}}, cur_q.grad_w_in}, v_q));
			last_out_q <= cur_q.last;
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issued_q  <= 1'b0;
			ovalid_q  <= 1'b0;
			sum_q     <= 64'd0;
			dot_q     <= 64'd0;
			cnt_q     <= '0;
			inv_rms_q <= 32'd0;
			coeff_q   <= 64'd0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start)
				issued_q <= 1'b1;
			else if (mul_done || div_done)
				issued_q <= 1'b0;
			if (load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
			if (state_q == ST_ACC) begin
				sum_q <= sat_add64(sum_q, sq_q);
				dot_q <= sat_add64(dot_q, px_q);
				if (cnt_q < CNT_W'(MAX_DIM))
					cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_SQRT && sbit_q == 64'd0)
				inv_rms_q <= sr_q[31:0];
			if (state_q == ST_COEF && mul_done) begin
				coeff_q <= mul_res;
				sum_q   <= 64'd0;
				dot_q   <= 64'd0;
				cnt_q   <= '0;
			end
		end
	end

	assign out_valid  = ovalid_q;
	assign grad_x_out = gx_out_q;
	assign grad_w_out = gw_out_q;
	assign last_out   = last_out_q;
	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.pop   = pop;
	assign stat.load  = load;

endmodule

// File: src/rmsnorm_backward_gradient.sv
// RMS-norm backward gradient: top level joining the input queue and the sequencer.
//
// Streams one vector in two passes. Mode 0 transfers accumulate sum(x*x) and
// sum(grad_out*weight*x) and produce no result; the transfer marked last also forms
// inv_rms = floor(2^30/sqrt(sum/n + eps)) and the coefficient inv^3/n*dot, then clears
// the accumulators. Mode 1 transfers each return one result transfer with
// grad_x_out = grad_x_in + inv*go*w - coeff*x and grad_w_out = grad_w_in + go*x*inv,
// all Q12.20, saturated. Items are handled one at a time by a sequencer that shares
// one 32x32 multiplier engine and one radix-2 64-bit divider. A mode 0 item runs
// three products; the last one of a vector adds three divisions, a 32-step square
// root and three products. A mode 1 item runs five products. A two-entry input
// queue and a result register let the input and output sides stall independently
// of the sequencer. Mode 1 before any mode 0 vector uses zero for inv_rms and the
// coefficient and returns the prior gradients.
module rmsnorm_backward_gradient (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] weight,
	input  logic signed [31:0] grad_out,
	input  logic signed [31:0] grad_x_in,
	input  logic signed [31:0] grad_w_in,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] grad_x_out,
	output logic signed [31:0] grad_w_out,
	output logic               last_out
);
	import rbg_pkg::*;

	`include "rmsnorm_backward_gradient_assert.svh"

	rbg_item_t      in_item, head;
	rbg_fq_stat_t   fstat;
	rbg_back_stat_t bstat;

	// pack the input ports into one queue entry
	assign in_item = '{mode: mode, x_value: x_value, weight: weight, grad_out: grad_out,
		grad_x_in: grad_x_in, grad_w_in: grad_w_in, last: last};

	// front: takes input transfers whenever the queue has room
	rbg_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.pop(bstat.pop), .head(head), .stat(fstat)
	);

	// back: pulls one item at a time and runs the arithmetic
	rbg_back u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .fstat(fstat),
		.out_ready(out_ready), .out_valid(out_valid),
		.grad_x_out(grad_x_out), .grad_w_out(grad_w_out), .last_out(last_out),
		.stat(bstat)
	);

	// the sequencer only pulls from a non-empty queue
	`RBG_ASSERT_SAME(a_pop_nonempty, bstat.pop, !fstat.empty)
	// an idle sequencer with work queued leaves idle on the next cycle
	`RBG_ASSERT_NEXT(a_idle_picks_up, bstat.idle && !fstat.empty, !bstat.idle)
	// a taken result with no new one behind it empties the result register
	`RBG_ASSERT_NEXT(a_out_drains, out_valid && out_ready && !bstat.load, !out_valid)

endmodule
